FILE: src/mdbb_pkg.sv
package mdbb_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PRINCIPAL_X     = 3'd0;
  localparam logic [2:0] CFG_PRINCIPAL_Y     = 3'd1;
  localparam logic [2:0] CFG_INV_FOCAL_X     = 3'd2;
  localparam logic [2:0] CFG_INV_FOCAL_Y     = 3'd3;
  localparam logic [2:0] CFG_INV_DEPTH_SCALE = 3'd4;

  // Reset values of the camera registers
  localparam logic [13:0] PRINCIPAL_X_RST     = 14'd5120;
  localparam logic [13:0] PRINCIPAL_Y_RST     = 14'd3840;
  localparam logic [23:0] INV_FOCAL_X_RST     = 24'd27962;
  localparam logic [23:0] INV_FOCAL_Y_RST     = 24'd27962;
  localparam logic [23:0] INV_DEPTH_SCALE_RST = 24'd16777;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Camera calibration as seen by front and back
  typedef struct packed {
    logic [13:0] principal_x;
    logic [13:0] principal_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [23:0] inv_depth_scale;
  } cam_cfg_t;

  // Classified pixel: offsets already in sign/magnitude form
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [15:0] label;
    logic [15:0] depth;
    logic        neg_x;
    logic [13:0] mag_x;
    logic        neg_y;
    logic [13:0] mag_y;
  } pixel_entry_t;

  // Result box; last member sits in the lowest bits
  typedef struct packed {
    logic        [31:0] z_max;
    logic        [31:0] z_min;
    logic signed [31:0] y_max;
    logic signed [31:0] y_min;
    logic signed [31:0] x_max;
    logic signed [31:0] x_min;
    logic        [15:0] label;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Z,
    ST_MAG,
    ST_PROD,
    ST_SAT,
    ST_ACC
  } back_state_t;

endpackage

FILE: src/mdbb_front.sv
module mdbb_front #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                  s_valid,
  output logic                  s_ready,
  input  logic [15:0]           depth_raw,
  input  logic [15:0]           mask_value,
  input  logic [9:0]            pixel_col,
  input  logic [8:0]            pixel_row,
  input  logic                  last_pixel,
  input  mdbb_pkg::cam_cfg_t    cfg,
  input  logic                  full,
  output logic                  push,
  output mdbb_pkg::pixel_entry_t entry
);

  logic               in_image;
  logic               usable;
  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic signed [14:0] ndx;
  logic signed [14:0] ndy;

  // Pixel lies inside the image and carries a measurement on the object
  assign in_image = ({3'b000, pixel_col} < 13'(IMAGE_WIDTH)) &&
                    ({4'b0000, pixel_row} < 13'(IMAGE_HEIGHT));
  assign usable   = (depth_raw != 16'd0) && (mask_value != 16'd0) && in_image;

  // Offsets from the principal point, signed Q11.4
  assign dx  = $signed({1'b0, pixel_col, 4'b0000}) - $signed({1'b0, cfg.principal_x});
  assign dy  = $signed({2'b00, pixel_row, 4'b0000}) - $signed({1'b0, cfg.principal_y});
  assign ndx = -dx;
  assign ndy = -dy;

  always_comb begin
    entry.valid = usable;
    entry.last  = last_pixel;
    entry.label = mask_value;
    entry.depth = depth_raw;
    entry.neg_x = dx[14];
    entry.mag_x = dx[14] ? ndx[13:0] : dx[13:0];
    entry.neg_y = dy[14];
    entry.mag_y = dy[14] ? ndy[13:0] : dy[13:0];
  end

  // Pixels that neither count nor close the frame are dropped here
  assign s_ready = !full;
  assign push    = s_valid && !full && (usable || last_pixel);

endmodule

FILE: src/mdbb_queue.sv
module mdbb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mdbb_pkg::pixel_entry_t wr_entry,
  input  logic                   pop,
  output mdbb_pkg::pixel_entry_t rd_entry,
  output logic                   empty,
  output logic                   full
);

  mdbb_pkg::pixel_entry_t        slots [mdbb_pkg::QUEUE_DEPTH];
  logic [mdbb_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [mdbb_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [mdbb_pkg::QUEUE_AW:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign empty    = (count == '0);
  assign full     = (count == (mdbb_pkg::QUEUE_AW+1)'(mdbb_pkg::QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/mdbb_back.sv
module mdbb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mdbb_pkg::cam_cfg_t     cfg,
  input  logic                   empty,
  input  mdbb_pkg::pixel_entry_t entry,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mdbb_pkg::box_t         out_box
);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  mdbb_pkg::back_state_t  state;
  mdbb_pkg::back_state_t  state_next;
  mdbb_pkg::pixel_entry_t item;

  logic [31:0]        z;
  logic [39:0]        z_prod;
  logic [45:0]        mag_x;
  logic [45:0]        mag_y;
  logic [45:0]        hi_x;
  logic [47:0]        lo_x;
  logic [45:0]        hi_y;
  logic [47:0]        lo_y;
  logic [46:0]        sum_x;
  logic [46:0]        sum_y;
  logic signed [31:0] x_sat;
  logic signed [31:0] y_sat;

  logic               any_seen;
  logic [15:0]        held_label;
  logic signed [31:0] run_x_min;
  logic signed [31:0] run_x_max;
  logic signed [31:0] run_y_min;
  logic signed [31:0] run_y_max;
  logic [31:0]        run_z_min;
  logic [31:0]        run_z_max;

  mdbb_pkg::box_t     upd;
  logic               seen_next;
  logic               emit;
  logic               acc_go;

  // Saturate a sign/magnitude Q16.16 value to signed 32 bits
  function automatic logic signed [31:0] saturate(input logic neg, input logic [42:0] q);
    logic [31:0] negq;
    negq = -q[31:0];
    if (neg) begin
      saturate = (q > 43'h0_8000_0000) ? S32_MIN : $signed(negq);
    end else begin
      saturate = (q > 43'h0_7FFF_FFFF) ? S32_MAX : $signed(q[31:0]);
    end
  endfunction

  assign z_prod = item.depth * cfg.inv_depth_scale;
  assign sum_x  = 47'(hi_x) + 47'(lo_x[47:24]);
  assign sum_y  = 47'(hi_y) + 47'(lo_y[47:24]);

  // Running box after this pixel
  always_comb begin
    upd.label = held_label;
    upd.x_min = run_x_min;
    upd.x_max = run_x_max;
    upd.y_min = run_y_min;
    upd.y_max = run_y_max;
    upd.z_min = run_z_min;
    upd.z_max = run_z_max;
    seen_next = any_seen;
    if (item.valid) begin
      upd.label = item.label;
      upd.x_min = (x_sat < run_x_min) ? x_sat : run_x_min;
      upd.x_max = (x_sat > run_x_max) ? x_sat : run_x_max;
      upd.y_min = (y_sat < run_y_min) ? y_sat : run_y_min;
      upd.y_max = (y_sat > run_y_max) ? y_sat : run_y_max;
      upd.z_min = (z < run_z_min) ? z : run_z_min;
      upd.z_max = (z > run_z_max) ? z : run_z_max;
      seen_next = 1'b1;
    end
  end

  assign emit   = item.last && seen_next;
  assign acc_go = (state == mdbb_pkg::ST_ACC) && !(emit && out_valid && !out_ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdbb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      mdbb_pkg::ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = entry.valid ? mdbb_pkg::ST_Z : mdbb_pkg::ST_ACC;
        end
      end
      mdbb_pkg::ST_Z:    state_next = mdbb_pkg::ST_MAG;
      mdbb_pkg::ST_MAG:  state_next = mdbb_pkg::ST_PROD;
      mdbb_pkg::ST_PROD: state_next = mdbb_pkg::ST_SAT;
      mdbb_pkg::ST_SAT:  state_next = mdbb_pkg::ST_ACC;
      mdbb_pkg::ST_ACC: begin
        if (acc_go) begin
          state_next = mdbb_pkg::ST_IDLE;
        end
      end
      default: state_next = mdbb_pkg::ST_IDLE;
    endcase
  end

  // Datapath: one multiplier rank per step
  always_ff @(posedge clk) begin
    if (state == mdbb_pkg::ST_IDLE && !empty) begin
      item <= entry;
    end
    if (state == mdbb_pkg::ST_Z) begin
      z <= z_prod[39:8];
    end
    if (state == mdbb_pkg::ST_MAG) begin
      mag_x <= item.mag_x * z;
      mag_y <= item.mag_y * z;
    end
    if (state == mdbb_pkg::ST_PROD) begin
      hi_x <= mag_x[45:24] * cfg.inv_focal_x;
      lo_x <= mag_x[23:0]  * cfg.inv_focal_x;
      hi_y <= mag_y[45:24] * cfg.inv_focal_y;
      lo_y <= mag_y[23:0]  * cfg.inv_focal_y;
    end
    if (state == mdbb_pkg::ST_SAT) begin
      x_sat <= saturate(item.neg_x, sum_x[46:4]);
      y_sat <= saturate(item.neg_y, sum_y[46:4]);
    end
  end

  // Running extent, cleared at the end of every frame
  always_ff @(posedge clk) begin
    if (rst) begin
      any_seen   <= 1'b0;
      held_label <= '0;
      run_x_min  <= S32_MAX;
      run_x_max  <= S32_MIN;
      run_y_min  <= S32_MAX;
      run_y_max  <= S32_MIN;
      run_z_min  <= '1;
      run_z_max  <= '0;
    end else if (acc_go) begin
      if (item.last) begin
        any_seen   <= 1'b0;
        held_label <= '0;
        run_x_min  <= S32_MAX;
        run_x_max  <= S32_MIN;
        run_y_min  <= S32_MAX;
        run_y_max  <= S32_MIN;
        run_z_min  <= '1;
        run_z_max  <= '0;
      end else begin
        any_seen   <= seen_next;
        held_label <= upd.label;
        run_x_min  <= upd.x_min;
        run_x_max  <= upd.x_max;
        run_y_min  <= upd.y_min;
        run_y_max  <= upd.y_max;
        run_z_min  <= upd.z_min;
        run_z_max  <= upd.z_max;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go && emit) begin
      out_box <= upd;
    end
  end

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (acc_go && item.last) |=> !any_seen)
    else $error("running state not cleared after the last pixel");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (acc_go && emit) |-> (!out_valid || out_ready))
    else $error("box written over a pending transaction");

  a_z_order: assert property (@(posedge clk) disable iff (rst)
    any_seen |-> (run_z_min <= run_z_max))
    else $error("depth extent inverted");

  a_x_order: assert property (@(posedge clk) disable iff (rst)
    any_seen |-> (run_x_min <= run_x_max && run_y_min <= run_y_max))
    else $error("lateral extent inverted");

endmodule

FILE: src/masked_depth_bounding_box_3d.sv
// Builds the 3-D bounding box of one object mask from a depth stream. Each pixel with
// nonzero depth and a nonzero mask value inside the image is back-projected through the
// pinhole model held in the configuration registers, and the running minimum and maximum
// of x, y and z (Q16.16 metres, x and y saturated) are kept. On the pixel marked tlast one
// box transaction is emitted, if any pixel counted, and the running state is cleared.
// Pixels that neither count nor close the frame are taken one per clock while the queue
// has room. A counting pixel passes the back-projection sequencer steps (queue pop, depth
// product, offset product, split focal product, saturation, min/max update); a last pixel
// that does not count goes from the pop to the min/max update. A four-entry queue sits
// before the sequencer, so the input accepts up to four counting or closing pixels while
// the sequencer is busy or a box waits on m_axis_tready; once it is full s_axis_tready
// drops. Configuration must be written only while the block is idle; it is not enforced.
module masked_depth_bounding_box_3d #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // depth_raw[15:0], mask_value[31:16], pixel_col[41:32], pixel_row[50:42], zero pad
  input  logic [55:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // object_label[15:0], x_min[47:16], x_max[79:48], y_min[111:80], y_max[143:112],
  // z_min[175:144], z_max[207:176]
  output logic [207:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  mdbb_pkg::cam_cfg_t     cfg;
  mdbb_pkg::pixel_entry_t wr_entry;
  mdbb_pkg::pixel_entry_t rd_entry;
  mdbb_pkg::box_t         box;
  logic                   push;
  logic                   pop;
  logic                   empty;
  logic                   full;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.principal_x     <= mdbb_pkg::PRINCIPAL_X_RST;
      cfg.principal_y     <= mdbb_pkg::PRINCIPAL_Y_RST;
      cfg.inv_focal_x     <= mdbb_pkg::INV_FOCAL_X_RST;
      cfg.inv_focal_y     <= mdbb_pkg::INV_FOCAL_Y_RST;
      cfg.inv_depth_scale <= mdbb_pkg::INV_DEPTH_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdbb_pkg::CFG_PRINCIPAL_X:     cfg.principal_x     <= cfg_data[13:0];
        mdbb_pkg::CFG_PRINCIPAL_Y:     cfg.principal_y     <= cfg_data[13:0];
        mdbb_pkg::CFG_INV_FOCAL_X:     cfg.inv_focal_x     <= cfg_data;
        mdbb_pkg::CFG_INV_FOCAL_Y:     cfg.inv_focal_y     <= cfg_data;
        mdbb_pkg::CFG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  mdbb_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .depth_raw  (s_axis_tdata[15:0]),
    .mask_value (s_axis_tdata[31:16]),
    .pixel_col  (s_axis_tdata[41:32]),
    .pixel_row  (s_axis_tdata[50:42]),
    .last_pixel (s_axis_tlast),
    .cfg        (cfg),
    .full       (full),
    .push       (push),
    .entry      (wr_entry)
  );

  mdbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (empty),
    .full     (full)
  );

  mdbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .entry     (rd_entry),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_box   (box)
  );

  assign m_axis_tdata = box;

endmodule
